// ===== hdl/lidar_point_time_from_azimuth_core_defines.svh =====
// Assertion macros shared by the point time stamping block.
// No dependencies.
`ifndef LIDAR_POINT_TIME_FROM_AZIMUTH_CORE_DEFINES_SVH
`define LIDAR_POINT_TIME_FROM_AZIMUTH_CORE_DEFINES_SVH
// implication checked on every edge outside reset
`define LPT_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lpt: same-cycle check failed");
// next-cycle implication
`define LPT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lpt: next-cycle check failed");
`endif

// ===== hdl/lpt_pkg.sv =====
// Shared types and constants for the lidar point time stamping block.
// No dependencies.
package lpt_pkg;
   localparam int NumRingsDefault = 32;
   localparam int CordicSteps = 16;
   localparam logic [21:0] TimeMax = 22'h3FFFFF;
   localparam int HalfTurn = 46080;
   localparam int FullTurn = 92160;

   typedef enum logic [2:0] {
      CSR_SCAN_RATE = 3'd0,
      CSR_TIME_UNIT = 3'd1,
      CSR_GIVEN_MODE = 3'd2,
      CSR_DECIMATION = 3'd3,
      CSR_BLIND = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      UNIT_S = 2'd0,
      UNIT_MS = 2'd1,
      UNIT_US = 2'd2,
      UNIT_NS = 2'd3
   } time_unit_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture input beat
      logic cordic_step;
      logic calc_lag;   // read ring state, form lag
      logic div_start;
      logic div_step;
      logic retry;      // add a turn and divide again
      logic finish;     // saturate, write back, decide emit
      logic dist_step;
   } lpt_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic given_mode;
      logic ring_bad;
      logic first_point;
      logic went_back;
      logic keep;
   } lpt_sts_type;

   function automatic logic [31:0] atan_entry(input logic [3:0] i);
      logic [31:0] r;
      case (i)
         4'd0: r = 32'd2949120;  4'd1: r = 32'd1740967;
         4'd2: r = 32'd919879;   4'd3: r = 32'd466945;
         4'd4: r = 32'd234379;   4'd5: r = 32'd117304;
         4'd6: r = 32'd58666;    4'd7: r = 32'd29335;
         4'd8: r = 32'd14668;    4'd9: r = 32'd7334;
         4'd10: r = 32'd3667;    4'd11: r = 32'd1833;
         4'd12: r = 32'd917;     4'd13: r = 32'd458;
         4'd14: r = 32'd229;     default: r = 32'd115;
      endcase
      return r;
   endfunction
endpackage

// ===== hdl/lpt_datapath.sv =====
// Datapath: CORDIC, lag divider, given-time scaling, distance check, ring state.
// Depends on lpt_pkg.
module lpt_datapath #(
   parameter int NUM_RINGS = lpt_pkg::NumRingsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  lpt_pkg::lpt_cmd_type cmd,
   output lpt_pkg::lpt_sts_type sts,
   input  logic [3:0]          step_idx,
   input  logic [5:0]          cfg_scan_rate,
   input  logic [1:0]          cfg_time_unit,
   input  logic                cfg_given_mode,
   input  logic [6:0]          cfg_decimation,
   input  logic [15:0]         cfg_blind,
   input  logic                in_frame_start,
   input  logic signed [19:0]  in_x,
   input  logic signed [19:0]  in_y,
   input  logic signed [19:0]  in_z,
   input  logic [15:0]         in_intensity,
   input  logic [4:0]          in_ring,
   input  logic [31:0]         in_raw_time,
   output logic signed [19:0]  out_x,
   output logic signed [19:0]  out_y,
   output logic signed [19:0]  out_z,
   output logic [15:0]         out_intensity,
   output logic [21:0]         out_time,
   output logic                out_sat
);
   import lpt_pkg::*;
   localparam int RingW = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
   localparam logic [37:0] GivenOver = 38'(TimeMax) + 38'd1;
   // ceil(2^38 / 1000): exact floor(n / 1000) for any n up to 2^32 + 499, so for every ns_sum
   localparam logic [28:0] NsRecip = 29'd274877907;

   logic signed [19:0] x_ff, y_ff, z_ff;
   logic [15:0] int_ff;
   logic [4:0] ring_ff;
   logic signed [42:0] cx_ff, cy_ff;
   logic signed [31:0] ang_ff;
   logic [NUM_RINGS-1:0] started_ff;
   logic signed [16:0] ref_yaw_ff [NUM_RINGS];
   logic [21:0] prev_ff [NUM_RINGS];
   logic [5:0] dcnt_ff;
   logic keep_ff;
   logic [17:0] lag_ff;
   logic [38:0] rem_ff;   // remainder
   logic [39:0] quo_ff;   // dividend, shifted out as quotient bits come in
   logic [37:0] given_ff;
   logic [21:0] time_ff;
   logic sat_ff;
   logic [41:0] dist_ff;
   logic [1:0] dsel_ff;
   logic [31:0] blind2_ff;
   logic went_back;

   logic ring_ok;
   logic [RingW-1:0] ridx;
   logic [6:0] dec_eff;
   logic [5:0] rate_eff;
   logic [16:0] den;
   logic signed [31:0] yaw_r;
   logic signed [16:0] yaw;
   logic signed [42:0] sx, sy;
   logic [19:0] absv;
   logic [39:0] sq;
   logic [32:0] ns_sum;
   logic [61:0] ns_prod;
   logic [37:0] given_val;

   assign ring_ok = ({3'b0, ring_ff} < 8'(NUM_RINGS));
   assign ridx = RingW'(ring_ff);
   assign dec_eff = (cfg_decimation == 7'd0) ? 7'd1 :
                    (cfg_decimation > 7'd64) ? 7'd64 : cfg_decimation;
   assign rate_eff = (cfg_scan_rate == 6'd0) ? 6'd1 : cfg_scan_rate;
   assign den = 17'd1444 * {11'd0, rate_eff};

   // round and fold the CORDIC angle
   always_comb begin
      yaw_r = (ang_ff + 32'sd128) >>> 8;
      if (yaw_r > 32'sd46080) yaw_r = yaw_r - 32'sd92160;
      if (yaw_r <= -32'sd46080) yaw_r = yaw_r + 32'sd92160;
      yaw = 17'(yaw_r);
   end

   assign sx = cx_ff >>> step_idx;
   assign sy = cy_ff >>> step_idx;

   always_comb begin
      case (dsel_ff)
         2'd0: absv = x_ff[19] ? 20'(-x_ff) : 20'(x_ff);
         2'd1: absv = y_ff[19] ? 20'(-y_ff) : 20'(y_ff);
         default: absv = z_ff[19] ? 20'(-z_ff) : 20'(z_ff);
      endcase
      sq = absv * absv;
   end

   // scale raw time; seconds and milliseconds values that would clip are set to GivenOver
   always_comb begin
      ns_sum = {1'b0, in_raw_time} + 33'd500;
      ns_prod = 62'(ns_sum) * 62'(NsRecip);
      case (time_unit_type'(cfg_time_unit))
         UNIT_S: given_val = (in_raw_time > 32'd4) ? GivenOver :
                             38'(in_raw_time[2:0]) * 38'd1000000;
         UNIT_MS: given_val = (in_raw_time > 32'd4194) ? GivenOver :
                              38'(in_raw_time[12:0]) * 38'd1000;
         UNIT_US: given_val = 38'(in_raw_time);
         default: given_val = 38'(ns_prod[61:38]);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= '0;
         dcnt_ff <= '0;
         for (int i = 0; i < NUM_RINGS; i++) begin
            ref_yaw_ff[i] <= '0;
            prev_ff[i] <= '0;
         end
      end else begin
         if (cmd.load) begin
            x_ff <= in_x; y_ff <= in_y; z_ff <= in_z;
            int_ff <= in_intensity; ring_ff <= in_ring;
            sat_ff <= 1'b0;
            dsel_ff <= 2'd0;
            dist_ff <= '0;
            blind2_ff <= cfg_blind * cfg_blind;
            if (in_frame_start) begin
               started_ff <= '0;
               keep_ff <= 1'b1;
               dcnt_ff <= (7'd1 >= dec_eff) ? 6'd0 : 6'd1;
            end else begin
               keep_ff <= (dcnt_ff == 6'd0);
               dcnt_ff <= ({1'b0, dcnt_ff} + 7'd1 >= dec_eff) ? 6'd0 : dcnt_ff + 6'd1;
            end
            if (in_x < 0) begin
               ang_ff <= (in_y >= 0) ? 32'sd11796480 : -32'sd11796480;
               cx_ff <= (-(43'(in_x))) <<< 20;
               cy_ff <= (-(43'(in_y))) <<< 20;
            end else begin
               ang_ff <= '0;
               cx_ff <= 43'(in_x) <<< 20;
               cy_ff <= 43'(in_y) <<< 20;
            end
            given_ff <= given_val;
         end
         // a zero vector holds its zero angle
         if (cmd.cordic_step && !(cx_ff == 0 && cy_ff == 0)) begin
            if (cy_ff >= 0) begin
               cx_ff <= cx_ff + sy; cy_ff <= cy_ff - sx;
               ang_ff <= ang_ff + $signed(atan_entry(step_idx));
            end else begin
               cx_ff <= cx_ff - sy; cy_ff <= cy_ff + sx;
               ang_ff <= ang_ff - $signed(atan_entry(step_idx));
            end
         end
         if (cmd.calc_lag && ring_ok) begin
            if (!started_ff[ridx]) begin
               started_ff[ridx] <= 1'b1;
               ref_yaw_ff[ridx] <= yaw;
               prev_ff[ridx] <= '0;
            end else if (yaw <= ref_yaw_ff[ridx]) begin
               lag_ff <= 18'(ref_yaw_ff[ridx]) - 18'(yaw);
            end else begin
               lag_ff <= 18'(18'(ref_yaw_ff[ridx]) - 18'(yaw) + 18'(FullTurn));
            end
         end
         if (cmd.retry) lag_ff <= lag_ff + 18'(FullTurn);
         if (cmd.div_start) begin
            quo_ff <= 40'(lag_ff) * 40'd15625 + 40'(den >> 1);
            rem_ff <= '0;
         end
         if (cmd.div_step) begin
            // shift in two dividend bits per step keeps count at 20
            logic [39:0] r1;
            logic [39:0] q1;
            r1 = {rem_ff, quo_ff[39]};
            q1 = {quo_ff[38:0], 1'b0};
            if (r1 >= 40'(den)) begin r1 = r1 - 40'(den); q1[0] = 1'b1; end
            r1 = {r1[38:0], q1[39]};
            q1 = {q1[38:0], 1'b0};
            if (r1 >= 40'(den)) begin r1 = r1 - 40'(den); q1[0] = 1'b1; end
            rem_ff <= 39'(r1);
            quo_ff <= q1;
         end
         if (cmd.finish) begin
            if (cfg_given_mode) begin
               if (given_ff > 38'(TimeMax)) begin
                  time_ff <= TimeMax; sat_ff <= 1'b1;
               end else time_ff <= 22'(given_ff);
            end else begin
               if (quo_ff > 40'(TimeMax)) begin
                  time_ff <= TimeMax; sat_ff <= 1'b1; prev_ff[ridx] <= TimeMax;
               end else begin
                  time_ff <= 22'(quo_ff); prev_ff[ridx] <= 22'(quo_ff);
               end
            end
         end
         if (cmd.dist_step) begin
            dist_ff <= dist_ff + 42'(sq);
            dsel_ff <= dsel_ff + 2'd1;
         end
      end
   end

   always_comb went_back = (quo_ff < 40'(prev_ff[ridx]));

   assign sts.given_mode = cfg_given_mode;
   assign sts.ring_bad = !ring_ok;
   assign sts.first_point = ring_ok && !started_ff[ridx];
   assign sts.went_back = went_back;
   assign sts.keep = keep_ff && (dist_ff > 42'(blind2_ff));

   assign out_x = x_ff;
   assign out_y = y_ff;
   assign out_z = z_ff;
   assign out_intensity = int_ff;
   assign out_time = time_ff;
   assign out_sat = sat_ff;
endmodule

// ===== hdl/lpt_controller.sv =====
// Sequencer for one point: load, CORDIC, lag, divide, finish, distance, emit.
// Depends on lpt_pkg and the assertion macro header.
`include "lidar_point_time_from_azimuth_core_defines.svh"
module lpt_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lpt_pkg::lpt_cmd_type cmd,
   input  lpt_pkg::lpt_sts_type sts,
   output logic [3:0]           step_idx
);
   import lpt_pkg::*;
   typedef enum logic [3:0] {
      S_IDLE, S_CORDIC, S_LAG, S_DSTART, S_DIV, S_CHECK, S_FIN, S_DIST, S_OUT
   } state_type;

   state_type state_ff;
   logic [4:0] cnt_ff;
   logic retried_ff;
   logic rsp_valid_ff;

   assign step_idx = cnt_ff[3:0];
   assign req_stall = (state_ff != S_IDLE) && !(state_ff == S_OUT && !rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.load = req_valid && !req_stall;
      case (state_ff)
         S_CORDIC: cmd.cordic_step = 1'b1;
         S_LAG: cmd.calc_lag = 1'b1;
         S_DSTART: cmd.div_start = 1'b1;
         S_DIV: cmd.div_step = 1'b1;
         S_CHECK: cmd.retry = sts.went_back && !retried_ff;
         S_FIN: cmd.finish = 1'b1;
         // accumulate x, y, z squares, then compare once all three are summed
         S_DIST: cmd.dist_step = (cnt_ff != 5'd3);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         retried_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE, S_OUT: begin
               if (state_ff == S_OUT && !rsp_stall) rsp_valid_ff <= 1'b0;
               if (cmd.load) begin
                  cnt_ff <= '0;
                  retried_ff <= 1'b0;
                  state_ff <= S_CORDIC;
               end else if (state_ff == S_OUT && !rsp_stall) state_ff <= S_IDLE;
            end
            S_CORDIC: begin
               if (sts.given_mode) begin
                  cnt_ff <= '0; state_ff <= S_FIN;
               end else if (cnt_ff == 5'(CordicSteps - 1)) state_ff <= S_LAG;
               else cnt_ff <= cnt_ff + 5'd1;
            end
            S_LAG: begin
               cnt_ff <= '0;
               state_ff <= (sts.ring_bad || sts.first_point) ? S_IDLE : S_DSTART;
            end
            S_DSTART: begin cnt_ff <= '0; state_ff <= S_DIV; end
            S_DIV: begin
               if (cnt_ff == 5'd19) state_ff <= S_CHECK;
               else cnt_ff <= cnt_ff + 5'd1;
            end
            S_CHECK: begin
               if (sts.went_back && !retried_ff) begin
                  retried_ff <= 1'b1; state_ff <= S_DSTART;
               end else state_ff <= S_FIN;
            end
            S_FIN: begin cnt_ff <= '0; state_ff <= S_DIST; end
            S_DIST: begin
               if (cnt_ff == 5'd3) begin
                  if (sts.keep) begin rsp_valid_ff <= 1'b1; state_ff <= S_OUT; end
                  else state_ff <= S_IDLE;
               end else cnt_ff <= cnt_ff + 5'd1;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `LPT_ASSERT_IMPL(a_rsp_only_out, rsp_valid, state_ff == S_OUT || state_ff == S_CORDIC)
   `LPT_ASSERT_IMPL(a_load_when_free, cmd.load, state_ff == S_IDLE || state_ff == S_OUT)
   `LPT_ASSERT_NEXT(a_load_starts, cmd.load, state_ff == S_CORDIC)
endmodule

// ===== hdl/lidar_point_time_from_azimuth_core.sv =====
// Top level of the lidar point time stamping block.
// Depends on lpt_pkg, lpt_controller and lpt_datapath.
// One point is handled at a time: req_stall stays high from the accepting edge until the
// point's result beat is taken or the point is dropped, and the next beat can be accepted
// at the edge that takes the result. An azimuth-mode point passes through 16 CORDIC
// iterations, a lag state, a divider start, the two-bit-per-cycle lag divider, a check
// state, a finish state, accumulation of the x, y and z squares through one squarer,
// a compare state and the output state. When the time would go backwards the divider
// runs again with one turn added. The first point of a ring and a ring out of range leave
// after the lag state. Given-time points go from the first CORDIC state straight to the
// finish state. A stalled result holds the input side off until it is taken.
module lidar_point_time_from_azimuth_core #(
   parameter int NUM_RINGS = lpt_pkg::NumRingsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_frame_start,
   input  logic signed [19:0] req_x_mm,
   input  logic signed [19:0] req_y_mm,
   input  logic signed [19:0] req_z_mm,
   input  logic [15:0]        req_intensity,
   input  logic [4:0]         req_ring,
   input  logic [31:0]        req_raw_time,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [19:0] rsp_x_out,
   output logic signed [19:0] rsp_y_out,
   output logic signed [19:0] rsp_z_out,
   output logic [15:0]        rsp_intensity_out,
   output logic [21:0]        rsp_time_us,
   output logic               rsp_time_saturated
);
   import lpt_pkg::*;

   logic [5:0] scan_rate_ff;
   logic [1:0] time_unit_ff;
   logic given_ff;
   logic [6:0] decimation_ff;
   logic [15:0] blind_ff;
   lpt_cmd_type cmd;
   lpt_sts_type sts;
   logic [3:0] step_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_rate_ff <= 6'd10;
         time_unit_ff <= 2'd1;
         given_ff <= 1'b0;
         decimation_ff <= 7'd1;
         blind_ff <= 16'd10;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_SCAN_RATE: scan_rate_ff <= csr_data[5:0];
            CSR_TIME_UNIT: time_unit_ff <= csr_data[1:0];
            CSR_GIVEN_MODE: given_ff <= csr_data[0];
            CSR_DECIMATION: decimation_ff <= csr_data[6:0];
            CSR_BLIND: blind_ff <= csr_data;
            default: ;
         endcase
      end
   end

   lpt_controller u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .sts, .step_idx
   );

   lpt_datapath #(.NUM_RINGS(NUM_RINGS)) u_dp (
      .clock, .reset, .cmd, .sts, .step_idx,
      .cfg_scan_rate(scan_rate_ff), .cfg_time_unit(time_unit_ff),
      .cfg_given_mode(given_ff), .cfg_decimation(decimation_ff), .cfg_blind(blind_ff),
      .in_frame_start(req_frame_start), .in_x(req_x_mm), .in_y(req_y_mm),
      .in_z(req_z_mm), .in_intensity(req_intensity), .in_ring(req_ring),
      .in_raw_time(req_raw_time),
      .out_x(rsp_x_out), .out_y(rsp_y_out), .out_z(rsp_z_out),
      .out_intensity(rsp_intensity_out), .out_time(rsp_time_us),
      .out_sat(rsp_time_saturated)
   );
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for lidar_point_time_from_azimuth_core: drives points,
// predicts time stamps, decimation and blind-zone drops, checks every result beat.
// Depends on lpt_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
   import lpt_pkg::*;

   typedef struct {
      bit               frame_start;
      logic signed [19:0] x, y, z;
      logic [15:0]      intensity;
      logic [4:0]       ring;
      logic [31:0]      raw_time;
   } lidar_point_type;

   typedef struct {
      logic signed [19:0] x, y, z;
      logic [15:0]      intensity;
      logic [21:0]      time_us;
      logic             saturated;
   } stamped_point_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_frame_start = 1'b0;
   logic signed [19:0] req_x_mm = '0, req_y_mm = '0, req_z_mm = '0;
   logic [15:0]        req_intensity = '0;
   logic [4:0]         req_ring = '0;
   logic [31:0]        req_raw_time = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [19:0] rsp_x_out, rsp_y_out, rsp_z_out;
   logic [15:0]        rsp_intensity_out;
   logic [21:0]        rsp_time_us;
   logic               rsp_time_saturated;

   lidar_point_time_from_azimuth_core i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block's registers and per-ring state
   int unsigned rate_q, unit_q, given_q, decim_q, blind_q;
   bit          ring_seen[32];
   int          ring_ref_yaw[32];
   longint      ring_prev_us[32];
   int unsigned decim_count;

   stamped_point_type stamped_q[$];
   int  mismatches = 0;
   bit  sender_idles = 1'b1, receiver_idles = 1'b1;
   int  quiet_cycles = 0;

   localparam longint AtanLut[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
      58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

   function automatic int azimuth(longint x, longint y);
      longint z, cx, cy, nx, ny, r;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? longint'(HalfTurn) * 256 : -longint'(HalfTurn) * 256;
         x = -x;
         y = -y;
      end
      cx = x * 1048576;
      cy = y * 1048576;
      for (int i = 0; i < 16; i++) begin
         if (cy >= 0) begin
            nx = cx + (cy >>> i);
            ny = cy - (cx >>> i);
            z += AtanLut[i];
         end else begin
            nx = cx - (cy >>> i);
            ny = cy + (cx >>> i);
            z -= AtanLut[i];
         end
         cx = nx;
         cy = ny;
      end
      r = (z + 128) >>> 8;
      if (r > HalfTurn) r -= FullTurn;
      if (r <= -HalfTurn) r += FullTurn;
      return int'(r);
   endfunction

   function automatic longint lag_us(longint lag, longint den);
      return (lag * 15625 + den / 2) / den;
   endfunction

   // work out the stamped point (if any) for one accepted beat
   function automatic void predict_stamp(lidar_point_type p);
      int unsigned dec, cnt;
      longint t, den, lag, xs, ys, zs;
      int yaw;
      bit sat;
      stamped_point_type s;
      sat = 1'b0;
      if (p.frame_start) begin
         ring_seen = '{default: 1'b0};
         decim_count = 0;
      end
      dec = (decim_q == 0) ? 1 : (decim_q > 64 ? 64 : decim_q);
      cnt = decim_count;
      decim_count = (cnt + 1 >= dec) ? 0 : cnt + 1;
      if (given_q != 0) begin
         case (time_unit_type'(unit_q))
            UNIT_S:  t = longint'(p.raw_time) * 1000000;
            UNIT_MS: t = longint'(p.raw_time) * 1000;
            UNIT_US: t = longint'(p.raw_time);
            default: t = (longint'(p.raw_time) + 500) / 1000;
         endcase
         if (t > TimeMax) begin
            t = TimeMax;
            sat = 1'b1;
         end
      end else begin
         den = 1444 * ((rate_q == 0) ? 1 : rate_q);
         yaw = azimuth(p.x, p.y);
         if (!ring_seen[p.ring]) begin
            ring_seen[p.ring] = 1'b1;
            ring_ref_yaw[p.ring] = yaw;
            ring_prev_us[p.ring] = 0;
            return;
         end
         lag = ring_ref_yaw[p.ring] - yaw;
         if (yaw > ring_ref_yaw[p.ring]) lag += FullTurn;
         t = lag_us(lag, den);
         if (t < ring_prev_us[p.ring]) t = lag_us(lag + FullTurn, den);
         if (t > TimeMax) begin
            t = TimeMax;
            sat = 1'b1;
         end
         ring_prev_us[p.ring] = t;
      end
      if (cnt != 0) return;
      xs = p.x;
      ys = p.y;
      zs = p.z;
      if (xs * xs + ys * ys + zs * zs <= longint'(blind_q) * blind_q) return;
      s.x = p.x;
      s.y = p.y;
      s.z = p.z;
      s.intensity = p.intensity;
      s.time_us = t[21:0];
      s.saturated = sat;
      stamped_q.insert(stamped_q.size(), s);
   endfunction

   task automatic send_point(lidar_point_type p);
      if (sender_idles && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_frame_start <= p.frame_start;
      req_x_mm <= p.x;
      req_y_mm <= p.y;
      req_z_mm <= p.z;
      req_intensity <= p.intensity;
      req_ring <= p.ring;
      req_raw_time <= p.raw_time;
      do @(posedge clock); while (req_stall);
      predict_stamp(p);
   endtask

   // drop valid, drain, let a dropped point finish, then load all registers
   task automatic configure(int unsigned rate, int unsigned unit, int unsigned given,
                            int unsigned decim, int unsigned blind);
      int unsigned vals[5];
      vals = '{rate, unit, given, decim, blind};
      req_valid <= 1'b0;
      while (stamped_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      for (int i = 0; i < 5; i++) begin
         csr_write <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_data <= vals[i][15:0];
         @(posedge clock);
      end
      csr_write <= 1'b0;
      rate_q = rate & 'h3F;
      unit_q = unit & 'h3;
      given_q = given & 'h1;
      decim_q = decim & 'h7F;
      blind_q = blind & 'hFFFF;
   endtask

   function automatic logic signed [19:0] rand_coord();
      int unsigned pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) return -20'sd524288;
      if (pick == 1) return 20'sd524287;
      if (pick == 2) return 20'sd0;
      if (pick < 9) return 20'($signed($urandom_range(0, 4000)) - 2000);
      return 20'($urandom);
   endfunction

   function automatic lidar_point_type rand_point(bit fs, logic [4:0] ring);
      lidar_point_type p;
      p.frame_start = fs;
      p.x = rand_coord();
      p.y = rand_coord();
      p.z = rand_coord();
      p.intensity = 16'($urandom);
      p.ring = ring;
      p.raw_time = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 5000);
      return p;
   endfunction

   function automatic lidar_point_type pt(bit fs, int x, int y, int z, int ring,
                                          int unsigned raw);
      lidar_point_type p;
      p = '{fs, 20'(x), 20'(y), 20'(z), 16'($urandom), 5'(ring), raw};
      return p;
   endfunction

   // frames of points over a few busy rings, with some stray frame starts
   task automatic run_frames(int n);
      logic [4:0] ring;
      bit fs;
      for (int k = 0; k < n; k++) begin
         fs = (k == 0) || ($urandom_range(0, 39) == 0);
         ring = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
         send_point(rand_point(fs, ring));
      end
   endtask

   task automatic test_azimuth_directed();
      configure(10, UNIT_MS, 0, 1, 10);
      send_point(pt(1, 1000, 0, 0, 0, 0));
      send_point(pt(0, 0, 1000, 0, 0, 0));
      send_point(pt(0, -1000, 0, 0, 0, 0));
      send_point(pt(0, -1000, -1, 0, 0, 0));
      send_point(pt(0, 0, 0, 0, 0, 0));
      send_point(pt(0, 0, 0, 500, 0, 0));
      send_point(pt(0, 10, 0, 0, 0, 0));
      send_point(pt(0, 11, 0, 0, 0, 0));
      send_point(pt(0, 524287, -524288, -524288, 0, 0));
      send_point(pt(0, -524288, 524287, 524287, 0, 0));
      send_point(pt(0, 700, 700, 0, 31, 0));
      send_point(pt(0, 700, -700, 0, 31, 0));
      send_point(pt(0, 700, 701, 0, 31, 0));
   endtask

   task automatic test_given_directed();
      for (int u = 0; u < 4; u++) begin
         configure(10, u, 1, 1, 10);
         send_point(pt(u == 0, 500, 0, 0, 0, 0));
         send_point(pt(0, 500, 0, 0, 3, 32'hFFFF_FFFF));
         send_point(pt(0, 500, 0, 0, 7, u == 3 ? 499 : 4));
         send_point(pt(0, 500, 0, 0, 7, u == 3 ? 500 : 4194304));
      end
      send_point(pt(0, 500, 0, 0, 7, 4194303));
   endtask

   task automatic test_decimation();
      configure(50, UNIT_MS, 0, 3, 0);
      run_frames(150);
      configure(0, UNIT_MS, 0, 0, 65535);
      run_frames(100);
      configure(1, UNIT_MS, 0, 127, 5);
      run_frames(200);
      configure(63, UNIT_MS, 0, 64, 100);
      run_frames(150);
   endtask

   task automatic test_random_azimuth();
      for (int k = 0; k < 4; k++) begin
         configure($urandom_range(1, 50), $urandom_range(0, 3), 0,
                   $urandom_range(1, 4), $urandom_range(0, 3000));
         run_frames(180);
      end
   endtask

   task automatic test_random_given();
      for (int k = 0; k < 4; k++) begin
         configure($urandom_range(0, 63), k, 1, $urandom_range(1, 3), $urandom_range(0, 65535));
         run_frames(60);
      end
   endtask

   task automatic test_full_rate();
      configure(10, UNIT_MS, 0, 1, 10);
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      run_frames(300);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      ring_seen = '{default: 1'b0};
      ring_ref_yaw = '{default: 0};
      ring_prev_us = '{default: 0};
      decim_count = 0;
      test_azimuth_directed();
      test_given_directed();
      test_decimation();
      test_random_azimuth();
      test_random_given();
      test_full_rate();
      req_valid <= 1'b0;
      while (stamped_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver stall bursts
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (receiver_idles && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 16) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      stamped_point_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stamped_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected beat, expected none, actual time_us %0d",
                     $time, rsp_time_us);
         end else begin
            e = stamped_q.pop_front();
            if (rsp_x_out !== e.x || rsp_y_out !== e.y || rsp_z_out !== e.z ||
                rsp_intensity_out !== e.intensity || rsp_time_us !== e.time_us ||
                rsp_time_saturated !== e.saturated) begin
               mismatches++;
               $display("%0t: expected x %0d y %0d z %0d int %0d t %0d sat %0d", $time,
                        e.x, e.y, e.z, e.intensity, e.time_us, e.saturated);
               $display("%0t: actual   x %0d y %0d z %0d int %0d t %0d sat %0d", $time,
                        rsp_x_out, rsp_y_out, rsp_z_out, rsp_intensity_out, rsp_time_us,
                        rsp_time_saturated);
            end
         end
      end
   end

   // hang detection: no beat moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end
endmodule
